@@ sv/ktc_pkg.sv @@
// Shared types and codes for the keyed table with compaction.
// Holds operation and status codes, the slot record and the cell control group.
// No dependencies.
`timescale 1ns / 1ps

package ktc_pkg;

	// Field widths of one table entry.
	localparam int KEY_W = 64;
	localparam int TYPE_W = 64;
	localparam int AMT_W = 32;
	localparam int OCC_W = 7;
	localparam int DEPTH_DEF = 16;

	// Operation codes.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;
	localparam logic [1:0] OP_LIST = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_DUP = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	// One table entry.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TYPE_W-1:0] typ;
		logic signed [AMT_W-1:0] amt;
	} slot_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic cmp_en;
		logic shift_en;
	} cell_ctl_t;

endpackage

@@ sv/ktc_cell.sv @@
// One slot of the keyed table: holds an entry, compares its key and takes
// its right neighbor's entry when the table compacts.
// Depends on ktc_pkg.
`timescale 1ns / 1ps

module ktc_cell (
	input logic clk,
	input logic arst_n,
	input ktc_pkg::cell_ctl_t ctl,
	input logic [ktc_pkg::KEY_W-1:0] cmp_key,
	input logic wr_en,
	input ktc_pkg::slot_t wr_slot,
	input ktc_pkg::slot_t nbr_slot,
	input logic hit_in,
	output logic hit_out,
	output logic match,
	output ktc_pkg::slot_t slot
);
	import ktc_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [TYPE_W-1:0] typ_q;
	logic signed [AMT_W-1:0] amt_q;
	logic move;

	// Key compare; on a remove, the matched cell and every cell behind it take the next entry.
	assign match = ctl.cmp_en && (key_q == cmp_key);
	assign hit_out = hit_in | match;
	assign move = ctl.shift_en && hit_out;

	// The key marks occupancy, so it resets to empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			key_q <= wr_slot.key;
		end else if (move) begin
			key_q <= nbr_slot.key;
		end
	end

	// Type tag and quantity follow the key.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			typ_q <= wr_slot.typ;
			amt_q <= wr_slot.amt;
		end else if (move) begin
			typ_q <= nbr_slot.typ;
			amt_q <= nbr_slot.amt;
		end
	end

	assign slot.key = key_q;
	assign slot.typ = typ_q;
	assign slot.amt = amt_q;

endmodule

@@ sv/keyed_table_with_compaction.sv @@
// Top level of the keyed table with compaction: command sequencer, cell chain
// and result registers.
// Depends on ktc_pkg and ktc_cell.
//
//   channel   handshake            payload
//   command   start / busy         op, key, item_type, amount
//   result    done (one cycle)     status, found_key, found_type, found_amount,
//                                  occupied, last
//
// Insert, remove and search first capture the command; then every cell
// compares its key and the chain writes or compacts. List reads out each
// occupied entry in turn through the select tree; an empty table gives a
// single result. Reset empties every slot at once. Results appear in the
// cycle after they are decided and cannot be stalled; a new command may
// start while one shows.
`timescale 1ns / 1ps

module keyed_table_with_compaction #(
	parameter int DEPTH = ktc_pkg::DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] op,
	input logic [ktc_pkg::KEY_W-1:0] key,
	input logic [ktc_pkg::TYPE_W-1:0] item_type,
	input logic signed [ktc_pkg::AMT_W-1:0] amount,
	output logic done,
	output logic [2:0] status,
	output logic [ktc_pkg::KEY_W-1:0] found_key,
	output logic [ktc_pkg::TYPE_W-1:0] found_type,
	output logic signed [ktc_pkg::AMT_W-1:0] found_amount,
	output logic [ktc_pkg::OCC_W-1:0] occupied,
	output logic last
);
	import ktc_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;

	logic [1:0] state_q;
	logic [1:0] op_q;
	slot_t cmd_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;

	cell_ctl_t ctl;
	slot_t cell_slot [DEPTH];
	logic [DEPTH:0] hit_c;
	logic [DEPTH-1:0] match_v;
	logic [DEPTH-1:0] sel_v;
	logic [DEPTH-1:0] wr_v;
	slot_t sel_slot;
	logic wr_en;
	logic hit;
	logic accept;
	logic list_last;

	logic res_emit;
	logic [2:0] res_status;
	slot_t res_slot;
	logic res_last;
	logic [CW-1:0] count_d;

	logic done_q;
	logic [2:0] status_q;
	slot_t out_q;
	logic [CW-1:0] occ_q;
	logic last_q;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Broadcast control to the chain.
	assign ctl.cmp_en = (state_q == S_EXEC) && (op_q != OP_LIST) && (cmd_q.key != '0);
	assign ctl.shift_en = (state_q == S_EXEC) && (op_q == OP_REMOVE);
	assign hit = |match_v;
	assign wr_en = (state_q == S_EXEC) && (op_q == OP_INSERT) && !hit
		&& (count_q != CW'(DEPTH)) && (cmd_q.key != '0);

	// Row of slot cells; each takes its right neighbor's entry on compaction.
	assign hit_c[0] = 1'b0;
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			slot_t nbr;
			if (gi < DEPTH - 1) begin : g_mid
				assign nbr = cell_slot[gi + 1];
			end else begin : g_end
				assign nbr = '0;
			end
			assign wr_v[gi] = wr_en && (count_q == CW'(gi));
			ktc_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.cmp_key(cmd_q.key),
				.wr_en(wr_v[gi]),
				.wr_slot(cmd_q),
				.nbr_slot(nbr),
				.hit_in(hit_c[gi]),
				.hit_out(hit_c[gi + 1]),
				.match(match_v[gi]),
				.slot(cell_slot[gi])
			);
		end
	endgenerate

	// Select the matched entry, or the entry at the list index, by an AND-OR tree.
	always_comb begin
		sel_slot = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_v[i] = (state_q == S_LIST) ? (idx_q == IW'(i)) : match_v[i];
			if (sel_v[i]) begin
				sel_slot = slot_t'(sel_slot | cell_slot[i]);
			end
		end
	end

	assign list_last = ((CW'(idx_q) + CW'(1)) == count_q);

	// Decide the result of the current step.
	always_comb begin
		res_emit = 1'b0;
		res_status = ST_OK;
		res_slot = '0;
		res_last = 1'b1;
		count_d = count_q;
		if (state_q == S_EXEC) begin
			case (op_q)
				OP_INSERT: begin
					res_emit = 1'b1;
					if (hit) begin
						res_status = ST_DUP;
						res_slot = sel_slot;
					end else if (count_q == CW'(DEPTH)) begin
						res_status = ST_FULL;
					end else if (cmd_q.key != '0) begin
						res_slot = cmd_q;
						count_d = count_q + CW'(1);
					end
				end
				OP_REMOVE: begin
					res_emit = 1'b1;
					if (hit) begin
						res_slot = sel_slot;
						count_d = count_q - CW'(1);
					end else begin
						res_status = ST_NOTFOUND;
					end
				end
				OP_SEARCH: begin
					res_emit = 1'b1;
					if (hit) begin
						res_slot = sel_slot;
					end else begin
						res_status = ST_NOTFOUND;
					end
				end
				default: begin
					if (count_q == '0) begin
						res_emit = 1'b1;
						res_status = ST_EMPTY;
					end
				end
			endcase
		end else if (state_q == S_LIST) begin
			res_emit = 1'b1;
			res_slot = sel_slot;
			res_last = list_last;
		end
	end

	// Command capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			cmd_q.key <= key;
			cmd_q.typ <= item_type;
			cmd_q.amt <= amount;
		end
	end

	// Sequencer, occupancy count and list index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
		end else begin
			count_q <= count_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					idx_q <= '0;
					if ((op_q == OP_LIST) && (count_q != '0)) begin
						state_q <= S_LIST;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_LIST: begin
					idx_q <= idx_q + IW'(1);
					if (list_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_emit;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (res_emit) begin
			status_q <= res_status;
			out_q <= res_slot;
			occ_q <= count_d;
			last_q <= res_last;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign found_key = out_q.key;
	assign found_type = out_q.typ;
	assign found_amount = out_q.amt;
	assign occupied = OCC_W'(occ_q);
	assign last = last_q;

`ifndef SYNTH
	// A list that is not finished delivers its next entry in the next cycle.
	a_list_continues: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("list transaction broke off before its final entry");

	// An accepted command always keeps the block busy for its execute cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && (state_q == S_EXEC))
		else $error("accepted transaction did not enter execute");

	// The occupancy count never exceeds the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("occupancy count beyond table depth");

	// An insert that stores an entry raises the count by one.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not advance the occupancy count");
`endif

endmodule

@@ bench/keyed_table_with_compaction_test.sv @@
// Self-checking bench for the keyed table with compaction.
// Drives insert, remove, search and list transactions and checks every result
// against a behavioral model of the table; depends on ktc_pkg and the RTL top.
`timescale 1ns / 1ps

module keyed_table_with_compaction_test;
	import ktc_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int CLK_PERIOD = 20;
	localparam int RESET_CYCLES = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = DEPTH + 4;
	localparam int MAX_SHOWN = 10;
	localparam int POOL_SIZE = 24;
	localparam int RANDOM_PER_PHASE = 24;

	// One result as the table reports it.
	typedef struct packed {
		logic [2:0] status;
		logic [KEY_W-1:0] ekey;
		logic [TYPE_W-1:0] etype;
		logic signed [AMT_W-1:0] eamount;
		logic [OCC_W-1:0] count;
		logic is_last;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = OP_SEARCH;
	logic [KEY_W-1:0] key = '0;
	logic [TYPE_W-1:0] item_type = '0;
	logic signed [AMT_W-1:0] amount = '0;
	logic busy;
	logic done;
	logic [2:0] status;
	logic [KEY_W-1:0] found_key;
	logic [TYPE_W-1:0] found_type;
	logic signed [AMT_W-1:0] found_amount;
	logic [OCC_W-1:0] occupied;
	logic last;

	// Model of the table contents.
	logic [KEY_W-1:0] model_keys [DEPTH] = '{default: '0};
	logic [TYPE_W-1:0] model_types [DEPTH] = '{default: '0};
	logic signed [AMT_W-1:0] model_amounts [DEPTH] = '{default: '0};

	table_result_t expected_results [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int mismatches = 0;
	int commands_sent = 0;
	int results_seen = 0;
	int full_refusals = 0;
	int idle_cycles = 0;

	keyed_table_with_compaction #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.key(key),
		.item_type(item_type),
		.amount(amount),
		.done(done),
		.status(status),
		.found_key(found_key),
		.found_type(found_type),
		.found_amount(found_amount),
		.occupied(occupied),
		.last(last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Number of occupied slots in the model.
	function automatic int model_count();
		int c;
		c = 0;
		for (int i = 0; i < DEPTH; i++)
			if (model_keys[i] != '0)
				c++;
		return c;
	endfunction

	// Apply one command to the model and queue the results it causes.
	task automatic predict_transaction(input logic [1:0] cmd, input logic [KEY_W-1:0] k,
			input logic [TYPE_W-1:0] t, input logic signed [AMT_W-1:0] a);
		int pos;
		int free_pos;
		int total;
		int n;
		table_result_t r;
		pos = DEPTH;
		if (k != '0)
			for (int i = DEPTH - 1; i >= 0; i--)
				if (model_keys[i] == k)
					pos = i;
		r = '0;
		r.is_last = 1'b1;
		case (cmd)
			OP_INSERT: begin
				if (pos < DEPTH) begin
					r.status = ST_DUP;
					r.ekey = model_keys[pos];
					r.etype = model_types[pos];
					r.eamount = model_amounts[pos];
				end else begin
					free_pos = DEPTH;
					for (int i = DEPTH - 1; i >= 0; i--)
						if (model_keys[i] == '0)
							free_pos = i;
					if (free_pos >= DEPTH) begin
						r.status = ST_FULL;
						full_refusals++;
					end else begin
						// A zero key reports ok but stores nothing.
						r.status = ST_OK;
						if (k != '0) begin
							model_keys[free_pos] = k;
							model_types[free_pos] = t;
							model_amounts[free_pos] = a;
							r.ekey = k;
							r.etype = t;
							r.eamount = a;
						end
					end
				end
				r.count = OCC_W'(model_count());
				expected_results.push_back(r);
			end
			OP_REMOVE: begin
				if (pos >= DEPTH) begin
					r.status = ST_NOTFOUND;
				end else begin
					r.status = ST_OK;
					r.ekey = model_keys[pos];
					r.etype = model_types[pos];
					r.eamount = model_amounts[pos];
					// Later entries move one slot toward the front.
					for (int i = pos; i < DEPTH - 1; i++) begin
						model_keys[i] = model_keys[i + 1];
						model_types[i] = model_types[i + 1];
						model_amounts[i] = model_amounts[i + 1];
					end
					model_keys[DEPTH - 1] = '0;
					model_types[DEPTH - 1] = '0;
					model_amounts[DEPTH - 1] = '0;
				end
				r.count = OCC_W'(model_count());
				expected_results.push_back(r);
			end
			OP_SEARCH: begin
				if (pos >= DEPTH) begin
					r.status = ST_NOTFOUND;
				end else begin
					r.status = ST_OK;
					r.ekey = model_keys[pos];
					r.etype = model_types[pos];
					r.eamount = model_amounts[pos];
				end
				r.count = OCC_W'(model_count());
				expected_results.push_back(r);
			end
			default: begin
				total = model_count();
				r.count = OCC_W'(total);
				if (total == 0) begin
					r.status = ST_EMPTY;
					expected_results.push_back(r);
				end else begin
					n = 0;
					for (int i = 0; i < DEPTH; i++) begin
						if (model_keys[i] != '0) begin
							r.status = ST_OK;
							r.ekey = model_keys[i];
							r.etype = model_types[i];
							r.eamount = model_amounts[i];
							r.is_last = (n + 1 == total);
							expected_results.push_back(r);
							n++;
						end
					end
				end
			end
		endcase
	endtask

	// Present one command and hold it until the table takes it; returns on the
	// rising edge after acceptance with start still high.
	task automatic send_command(input logic [1:0] cmd, input logic [KEY_W-1:0] k,
			input logic [TYPE_W-1:0] t, input logic signed [AMT_W-1:0] a);
		bit taken;
		start <= 1'b1;
		op <= cmd;
		key <= k;
		item_type <= t;
		amount <= a;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		predict_transaction(cmd, k, t, a);
		commands_sent++;
	endtask

	// Stop sending and let every outstanding result arrive.
	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Empty-table behavior and zero keys.
	task automatic test_empty_table();
		send_command(OP_LIST, '0, '0, '0);
		send_command(OP_SEARCH, '0, '0, '0);
		send_command(OP_REMOVE, '0, '0, '0);
		send_command(OP_REMOVE, key_pool[5], '0, '0);
		send_command(OP_INSERT, '0, {TYPE_W{1'b1}}, 32'sd77);
		wait_for_results();
	endtask

	// Fill every slot, several with extreme field values, then try duplicates and overflow.
	task automatic test_fill_to_full();
		logic [TYPE_W-1:0] t;
		logic signed [AMT_W-1:0] a;
		for (int i = 0; i < DEPTH; i++) begin
			t = {$urandom, $urandom};
			a = $urandom;
			if (i == 0)
				t = {TYPE_W{1'b1}};
			if (i == 1)
				t = '0;
			if (i == 2)
				a = {1'b1, {(AMT_W - 1){1'b0}}};
			if (i == 3)
				a = {1'b0, {(AMT_W - 1){1'b1}}};
			if (i == 4)
				a = -1;
			send_command(OP_INSERT, key_pool[i], t, a);
		end
		send_command(OP_INSERT, key_pool[3], '0, '0);
		send_command(OP_INSERT, key_pool[20], {TYPE_W{1'b1}}, -1);
		send_command(OP_INSERT, '0, '0, '0);
		send_command(OP_LIST, '0, '0, '0);
		wait_for_results();
	endtask

	// Removal at the front, the middle and the back, with the list after it.
	task automatic test_compaction();
		send_command(OP_SEARCH, key_pool[7], '0, '0);
		send_command(OP_REMOVE, key_pool[0], '0, '0);
		send_command(OP_REMOVE, key_pool[8], '0, '0);
		send_command(OP_REMOVE, key_pool[DEPTH - 1], '0, '0);
		send_command(OP_LIST, '0, '0, '0);
		wait_for_results();
	endtask

	// Random traffic over a small key pool so that hits, duplicates and a full
	// table all occur; idle_pct is the chance that the sender stays idle in a
	// given cycle between commands.
	task automatic test_random_traffic(input int idle_pct, input int count);
		int pick;
		logic [1:0] cmd;
		logic [KEY_W-1:0] k;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				cmd = OP_INSERT;
			else if (pick < 65)
				cmd = OP_REMOVE;
			else if (pick < 90)
				cmd = OP_SEARCH;
			else
				cmd = OP_LIST;
			pick = $urandom_range(0, 99);
			if (pick < 90)
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else if (pick < 95)
				k = {$urandom, $urandom};
			else
				k = '0;
			send_command(cmd, k, {$urandom, $urandom}, $urandom);
			// Halfway through, hold off until the table has answered everything.
			if (n == count / 2) begin
				wait_for_results();
			end else begin
				while ($urandom_range(0, 99) < idle_pct) begin
					start <= 1'b0;
					@(posedge clk);
				end
			end
		end
		wait_for_results();
	endtask

	// Compare each result with the oldest expectation.
	always @(negedge clk) begin
		table_result_t got;
		table_result_t want;
		if (arst_n && done) begin
			got.status = status;
			got.ekey = found_key;
			got.etype = found_type;
			got.eamount = found_amount;
			got.count = occupied;
			got.is_last = last;
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("result %0d arrived with none expected: status=%0d key=%h",
						results_seen, got.status, got.ekey);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN) begin
						$display("result %0d expected: st=%0d key=%h type=%h amt=%0d occ=%0d last=%b",
							results_seen, want.status, want.ekey, want.etype, want.eamount,
							want.count, want.is_last);
						$display("result %0d actual:   st=%0d key=%h type=%h amt=%0d occ=%0d last=%b",
							results_seen, got.status, got.ekey, got.etype, got.eamount,
							got.count, got.is_last);
					end
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long.
	always @(negedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d cycles with no transaction", IDLE_LIMIT);
			$display("keyed_table_with_compaction: mismatch");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		for (int i = 0; i < POOL_SIZE; i++) begin
			key_pool[i] = {$urandom, $urandom};
			if (key_pool[i] == '0)
				key_pool[i] = KEY_W'(1);
		end
		key_pool[0] = {KEY_W{1'b1}};
		key_pool[1] = KEY_W'(1);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_fill_to_full();
		test_compaction();
		test_random_traffic(0, RANDOM_PER_PHASE);
		test_random_traffic(48, RANDOM_PER_PHASE);
		test_random_traffic(7, RANDOM_PER_PHASE);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d commands producing %0d results; %0d inserts were refused on a full table.",
			commands_sent, results_seen, full_refusals);
		$display("Mismatches counted: %0d.", mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("keyed_table_with_compaction: match");
		else
			$display("keyed_table_with_compaction: mismatch");
		$finish;
	end

endmodule
